// ===== design/pls_pkg.sv =====
`timescale 1ns / 1ps

package pls_pkg;

  // Fixed field widths of the words on the ports.
  localparam int STATE_W  = 10;
  localparam int HANDLE_W = 12;
  localparam int LIMIT_W  = 13;

  // Defaults for the top-level sizing parameters.
  localparam int DEF_MAX_STATES = 1024;
  localparam int DEF_MAX_EDGES  = 4096;

  // Transition limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // Action codes of an input word.
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_OLDEST = 2'd1,
    ACT_BEGIN  = 2'd2,
    ACT_STEP   = 2'd3
  } action_t;

  // Status codes of a result word.
  typedef enum logic [2:0] {
    STS_ADDED = 3'd0,
    STS_SELF  = 3'd1,
    STS_DUP   = 3'd2,
    STS_OVER  = 3'd3,
    STS_READ  = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ADD_CHK,
    S_WALK,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [STATE_W-1:0]  source;
    logic [STATE_W-1:0]  target;
    logic [HANDLE_W-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                found;
    logic [STATE_W-1:0]  predecessor;
    logic [HANDLE_W-1:0] next_handle;
    logic                has_next;
  } out_word_t;

endpackage

// ===== design/pls_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port synchronous RAM with a registered read port.
module pls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pls_ctrl.sv =====
`timescale 1ns / 1ps

module pls_ctrl #(
  parameter int MAX_STATES = pls_pkg::DEF_MAX_STATES,
  parameter int MAX_EDGES  = pls_pkg::DEF_MAX_EDGES,
  localparam int SW  = $clog2(MAX_STATES),
  localparam int EW  = $clog2(MAX_EDGES),
  localparam int CW  = EW + 1,
  localparam int HWW = EW + 1,
  localparam int EWW = pls_pkg::STATE_W + 1 + EW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pls_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pls_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pls_pkg::LIMIT_W-1:0]  cfg_data,
  output logic                         head_we,
  output logic [SW-1:0]                head_waddr,
  output logic [HWW-1:0]               head_wdata,
  output logic                         head_re,
  output logic [SW-1:0]                head_raddr,
  input  logic [HWW-1:0]               head_rdata,
  output logic                         entry_we,
  output logic [EW-1:0]                entry_waddr,
  output logic [EWW-1:0]               entry_wdata,
  output logic                         entry_re,
  output logic [EW-1:0]                entry_raddr,
  input  logic [EWW-1:0]               entry_rdata
);

  pls_pkg::ctrl_state_t state, state_next;
  logic [SW-1:0]                clr_addr;
  pls_pkg::in_word_t            item;
  logic [CW-1:0]                edge_count;
  logic [pls_pkg::LIMIT_W-1:0]  limit;
  pls_pkg::out_word_t           res, res_next;
  logic                         count_inc;

  logic [31:0]                  tgt_in32, hnd_in32, tgt32, h32, link32;
  logic [SW-1:0]                head_idx_in, head_idx;
  logic                         tgt_ok, hv, dup, full, step_bad, link_live;
  logic [EW-1:0]                h, e_link;
  logic [pls_pkg::STATE_W-1:0]  e_src;
  logic                         e_lv;

  // Index conversions between the fixed port widths and the memory sizes.
  assign tgt_in32    = 32'(in_data.target);
  assign hnd_in32    = 32'(in_data.handle);
  assign tgt32       = 32'(item.target);
  assign head_idx_in = tgt_in32[SW-1:0];
  assign head_idx    = tgt32[SW-1:0];
  assign tgt_ok      = tgt32 < 32'(MAX_STATES);

  // Fields of the head word and the entry word last read.
  assign hv     = head_rdata[EW] && tgt_ok;
  assign h      = head_rdata[EW-1:0];
  assign e_src  = entry_rdata[EWW-1 -: pls_pkg::STATE_W];
  assign e_lv   = entry_rdata[EW];
  assign e_link = entry_rdata[EW-1:0];
  assign h32    = 32'(h);
  assign link32 = 32'(e_link);

  // Decisions on the current word.
  assign dup       = hv && (e_src == item.source);
  assign full      = (32'(edge_count) >= 32'(limit)) || (32'(edge_count) >= 32'(MAX_EDGES));
  assign step_bad  = (32'(item.handle) >= 32'(edge_count))
                  || (32'(item.handle) >= 32'(MAX_EDGES));
  assign link_live = e_lv && (link32 < 32'(edge_count));

  assign cfg_ready = 1'b1;

  // State register, clearing sweep, edge count and limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pls_pkg::S_CLEAR;
      clr_addr   <= '0;
      edge_count <= '0;
      limit      <= pls_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;
      if (state == pls_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + SW'(1);
      end
      if (count_inc) begin
        edge_count <= edge_count + CW'(1);
      end
      if (cfg_valid) begin
        limit <= cfg_data;
      end
    end
  end

  // Captured input word and pending result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    res <= res_next;
  end

  // Output register: takes the pending result once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pls_pkg::S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pls_pkg::S_FIN && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    head_we     = 1'b0;
    head_waddr  = clr_addr;
    head_wdata  = '0;
    head_re     = 1'b0;
    head_raddr  = head_idx_in;
    entry_we    = 1'b0;
    entry_waddr = edge_count[EW-1:0];
    entry_wdata = {item.source, hv, h};
    entry_re    = 1'b0;
    entry_raddr = h;
    count_inc   = 1'b0;
    res_next    = res;
    case (state)
      pls_pkg::S_CLEAR: begin
        head_we = 1'b1;
        if (clr_addr == SW'(MAX_STATES - 1)) begin
          state_next = pls_pkg::S_IDLE;
        end
      end
      pls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          head_re     = 1'b1;
          entry_re    = 1'b1;
          entry_raddr = hnd_in32[EW-1:0];
          state_next  = pls_pkg::S_LOOK;
        end
      end
      pls_pkg::S_LOOK: begin
        res_next = '0;
        res_next.status = pls_pkg::STS_READ;
        state_next = pls_pkg::S_FIN;
        case (item.action)
          pls_pkg::ACT_ADD: begin
            if (item.source == item.target) begin
              res_next.status = pls_pkg::STS_SELF;
            end else if (!tgt_ok) begin
              res_next.status = pls_pkg::STS_OVER;
            end else begin
              // Fetch the newest entry for the duplicate check.
              entry_re   = 1'b1;
              state_next = pls_pkg::S_ADD_CHK;
            end
          end
          pls_pkg::ACT_OLDEST: begin
            if (hv && (h32 < 32'(edge_count))) begin
              entry_re   = 1'b1;
              state_next = pls_pkg::S_WALK;
            end
          end
          pls_pkg::ACT_BEGIN: begin
            if (hv) begin
              res_next.next_handle = h32[pls_pkg::HANDLE_W-1:0];
              res_next.has_next    = 1'b1;
            end
          end
          default: begin
            if (!step_bad) begin
              res_next.found       = 1'b1;
              res_next.predecessor = e_src;
              if (e_lv) begin
                res_next.next_handle = link32[pls_pkg::HANDLE_W-1:0];
                res_next.has_next    = 1'b1;
              end
            end
          end
        endcase
      end
      pls_pkg::S_ADD_CHK: begin
        state_next = pls_pkg::S_FIN;
        if (dup) begin
          res_next.status = pls_pkg::STS_DUP;
        end else if (full) begin
          res_next.status = pls_pkg::STS_OVER;
        end else begin
          // Prepend: new entry links to the old head, head points at it.
          entry_we   = 1'b1;
          head_we    = 1'b1;
          head_waddr = head_idx;
          head_wdata = {1'b1, edge_count[EW-1:0]};
          count_inc  = 1'b1;
          res_next.status = pls_pkg::STS_ADDED;
        end
      end
      pls_pkg::S_WALK: begin
        if (link_live) begin
          entry_re    = 1'b1;
          entry_raddr = e_link;
        end else begin
          res_next.found       = 1'b1;
          res_next.predecessor = e_src;
          state_next           = pls_pkg::S_FIN;
        end
      end
      pls_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = pls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pls_pkg::S_IDLE;
      end
    endcase
  end

  // The edge count never runs past the entry memory.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= 32'(MAX_EDGES))
    else $error("edge count beyond entry memory");

  // A stored edge advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count_inc |=> edge_count == $past(edge_count) + CW'(1))
    else $error("edge count did not advance on a stored edge");

  // A list walk only follows links to written entries.
  a_walk_written: assert property (@(posedge clk) disable iff (rst)
    (state == pls_pkg::S_WALK && entry_re) |-> 32'(entry_raddr) < 32'(edge_count))
    else $error("list walk reads an unwritten entry");

  // No word is taken or delivered before the head table is cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == pls_pkg::S_CLEAR |-> !in_ready && !out_valid)
    else $error("activity during head table clear");

endmodule

// ===== design/predecessor_list_store.sv =====
`timescale 1ns / 1ps

// Predecessor list store: keeps a newest-first linked list of source states
// for every target state, in a head table (one word per target) and an entry
// memory (one word per stored edge, allocated in order). After reset the head
// table is swept clean, one entry a cycle; during that sweep no word is
// accepted, while configuration writes are taken at any time. Words are then
// handled one at a time: an add goes through a lookup, a duplicate check and
// a finish state (a self-loop or an out-of-range target skips the check), a
// begin or a step through the lookup and finish states, and an oldest query
// walks the target's list between them, one entry memory read per cycle. Both
// memories have registered reads; a stalled output delays the return to idle.
module predecessor_list_store #(
  parameter int MAX_STATES = pls_pkg::DEF_MAX_STATES,
  parameter int MAX_EDGES  = pls_pkg::DEF_MAX_EDGES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pls_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pls_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pls_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int SW  = $clog2(MAX_STATES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int HWW = EW + 1;
  localparam int EWW = pls_pkg::STATE_W + 1 + EW;

  logic           head_we, head_re;
  logic [SW-1:0]  head_waddr, head_raddr;
  logic [HWW-1:0] head_wdata, head_rdata;
  logic           entry_we, entry_re;
  logic [EW-1:0]  entry_waddr, entry_raddr;
  logic [EWW-1:0] entry_wdata, entry_rdata;

  // Sequencer: decodes each word and drives both memories.
  pls_ctrl #(
    .MAX_STATES (MAX_STATES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .head_we     (head_we),
    .head_waddr  (head_waddr),
    .head_wdata  (head_wdata),
    .head_re     (head_re),
    .head_raddr  (head_raddr),
    .head_rdata  (head_rdata),
    .entry_we    (entry_we),
    .entry_waddr (entry_waddr),
    .entry_wdata (entry_wdata),
    .entry_re    (entry_re),
    .entry_raddr (entry_raddr),
    .entry_rdata (entry_rdata)
  );

  // Head table: valid bit and newest entry index per target.
  pls_ram #(
    .WIDTH (HWW),
    .DEPTH (MAX_STATES)
  ) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // Entry memory: source state and link to the next older entry.
  pls_ram #(
    .WIDTH (EWW),
    .DEPTH (MAX_EDGES)
  ) u_entry (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (entry_wdata),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

endmodule
